FILE: sv/pbsd_pkg.sv
// shared types, constants and helpers for the point to box squared distance block
// no dependencies

package pbsd_pkg;

  // coordinates are signed q8.8, squared distance is unsigned q20.16
  localparam int unsigned COORD_W   = 16;
  localparam int unsigned SQ_W      = 2 * COORD_W;
  localparam int unsigned SUM_W     = SQ_W + 2;
  localparam int unsigned DIST_W    = 36;
  localparam int unsigned EXT_W     = (SUM_W > DIST_W) ? SUM_W : DIST_W;
  localparam int unsigned NUM_AXES  = 3;
  localparam int unsigned CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOW_X  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LOW_Y  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_LOW_Z  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_X = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_Y = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_Z = CFG_IDX_W'(5);

  typedef logic signed [COORD_W-1:0] coord_t;

  // reset box spans 0.0 to 1.0 on every axis
  localparam coord_t LOW_RESET  = COORD_W'(0);
  localparam coord_t HIGH_RESET = COORD_W'(256);

  // which bound the clamp picked on one axis
  typedef enum logic [1:0] {
    CLAMP_NONE,
    CLAMP_LOW,
    CLAMP_HIGH
  } clamp_e;

  typedef struct packed {
    coord_t px;
    coord_t py;
    coord_t pz;
  } point_in_t;

  typedef struct packed {
    logic [DIST_W-1:0] min_sq_distance;
    logic              inside_res;
  } dist_out_t;

  // stage load enables handed to the axis units
  typedef struct packed {
    logic s2;
    logic s3;
  } axis_en_t;

  // clip a sum of squares to the result width
  function automatic logic [DIST_W-1:0] sat_dist(input logic [SUM_W-1:0] s);
    logic [EXT_W-1:0] e;
    e = EXT_W'(s);
    if ((e >> DIST_W) != '0) begin
      return '1;
    end
    return e[DIST_W-1:0];
  endfunction

endpackage

FILE: sv/point_box_squared_distance.sv
// point to axis-aligned box squared distance, top level
// depends on pbsd_pkg and pbsd_axis
// a taken point moves through the stages in order; its result word shows on the output from the stage 6 register
// throughput: one point per cycle while out_stall_i is low; six register stages, each moves when the next can take it
// the multiplier stage squares both bound differences of every axis once per cycle in which it loads
// reset clears all stage valids and sets the box to 0.0 .. 1.0 on every axis

module point_box_squared_distance
  import pbsd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // point input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  point_in_t            in_data_i,
  // result output channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output dist_out_t            out_data_o,
  // configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  coord_t               cfg_data_i
);

  localparam int unsigned NUM_STAGES = 6;
  localparam int unsigned NUM_CAND   = NUM_AXES + 1;

  // box registers
  coord_t lo_q [NUM_AXES];
  coord_t hi_q [NUM_AXES];

  // stage control: a stage loads when it is empty or the one after it moves on
  logic [NUM_STAGES-1:0] valid_q;
  logic [NUM_STAGES-1:0] ready;

  // stage 1: registered point
  coord_t p1_q [NUM_AXES];

  // stages 2 and 3 live in the axis units
  axis_en_t        axis_en;
  logic [SQ_W-1:0] sq_lo [NUM_AXES];
  logic [SQ_W-1:0] sq_hi [NUM_AXES];
  clamp_e          clamp [NUM_AXES];
  logic [NUM_AXES-1:0] inside_ax;

  // stage 4: per axis best pinned term and clamped term
  logic [SQ_W-1:0] pin4_q [NUM_AXES];
  logic [SQ_W-1:0] clp4_q [NUM_AXES];
  logic            inside4_q;

  // stage 5: candidate sums, one per face pair and one for the corners
  logic [DIST_W-1:0] cand5_q [NUM_CAND];
  logic              inside5_q;

  // stage 6: output word
  dist_out_t out_q;
  logic [DIST_W-1:0] min_a, min_b, min_all;

  // config port never back-pressures; user must write only while idle, not enforced
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        lo_q[k] <= LOW_RESET;
        hi_q[k] <= HIGH_RESET;
      end
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_LOW_X:  lo_q[0] <= cfg_data_i;
        REG_LOW_Y:  lo_q[1] <= cfg_data_i;
        REG_LOW_Z:  lo_q[2] <= cfg_data_i;
        REG_HIGH_X: hi_q[0] <= cfg_data_i;
        REG_HIGH_Y: hi_q[1] <= cfg_data_i;
        REG_HIGH_Z: hi_q[2] <= cfg_data_i;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // ready ripples back from the output stall
  always_comb begin
    ready[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || !out_stall_i;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      ready[i] = !valid_q[i] || ready[i+1];
    end
  end

  assign in_stall_o = !ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ready[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (ready[i]) begin
          valid_q[i] <= valid_q[i-1];
        end
      end
    end
  end

  // stage 1: take the point word
  always_ff @(posedge clk_i) begin
    if (ready[0]) begin
      p1_q[0] <= in_data_i.px;
      p1_q[1] <= in_data_i.py;
      p1_q[2] <= in_data_i.pz;
    end
  end

  assign axis_en.s2 = ready[1];
  assign axis_en.s3 = ready[2];

  // stages 2 and 3: differences to both bounds, then their squares
  for (genvar k = 0; k < NUM_AXES; k++) begin : g_axis
    pbsd_axis u_axis (
      .clk_i     (clk_i),
      .en_i      (axis_en),
      .p_i       (p1_q[k]),
      .lo_i      (lo_q[k]),
      .hi_i      (hi_q[k]),
      .sq_low_o  (sq_lo[k]),
      .sq_high_o (sq_hi[k]),
      .clamp_o   (clamp[k]),
      .inside_o  (inside_ax[k])
    );
  end

  // stage 4: a face pins its own axis to one plane, the nearer plane wins;
  // the other axes take the clamped term, which is zero or one of the two squares
  always_ff @(posedge clk_i) begin
    if (ready[3]) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        pin4_q[k] <= (sq_lo[k] < sq_hi[k]) ? sq_lo[k] : sq_hi[k];
        case (clamp[k])
          CLAMP_LOW:  clp4_q[k] <= sq_lo[k];
          CLAMP_HIGH: clp4_q[k] <= sq_hi[k];
          default:    clp4_q[k] <= '0;
        endcase
      end
      inside4_q <= &inside_ax;
    end
  end

  // stage 5: best face of each axis pair, and the nearest corner
  always_ff @(posedge clk_i) begin
    if (ready[4]) begin
      cand5_q[0] <= sat_dist(SUM_W'(pin4_q[0]) + SUM_W'(clp4_q[1]) + SUM_W'(clp4_q[2]));
      cand5_q[1] <= sat_dist(SUM_W'(clp4_q[0]) + SUM_W'(pin4_q[1]) + SUM_W'(clp4_q[2]));
      cand5_q[2] <= sat_dist(SUM_W'(clp4_q[0]) + SUM_W'(clp4_q[1]) + SUM_W'(pin4_q[2]));
      cand5_q[3] <= sat_dist(SUM_W'(pin4_q[0]) + SUM_W'(pin4_q[1]) + SUM_W'(pin4_q[2]));
      inside5_q  <= inside4_q;
    end
  end

  // stage 6: two-level minimum into the output register
  always_comb begin
    min_a   = (cand5_q[0] < cand5_q[1]) ? cand5_q[0] : cand5_q[1];
    min_b   = (cand5_q[2] < cand5_q[3]) ? cand5_q[2] : cand5_q[3];
    min_all = (min_a < min_b) ? min_a : min_b;
  end

  always_ff @(posedge clk_i) begin
    if (ready[5]) begin
      out_q.min_sq_distance <= min_all;
      out_q.inside_res      <= inside5_q;
    end
  end

  assign out_valid_o = valid_q[NUM_STAGES-1];
  assign out_data_o  = out_q;

  // a result word only appears when stage 5 held one
  a_out_from_stage5 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(valid_q[NUM_STAGES-2]))
    else $error("output valid rose without a word in stage 5");

  // the minimum never exceeds the corner candidate it was built from
  a_min_le_corner : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ready[NUM_STAGES-1] && valid_q[NUM_STAGES-2])
      |=> (out_q.min_sq_distance <= $past(cand5_q[NUM_CAND-1])))
    else $error("minimum above corner candidate");

  // an empty output stage must never back-pressure the input
  a_no_stall_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output stage empty");

endmodule

FILE: sv/pbsd_axis.sv
// one axis of the distance pipeline: bound differences, clamp choice and squares
// depends on pbsd_pkg

module pbsd_axis
  import pbsd_pkg::*;
(
  input  logic                clk_i,
  input  axis_en_t            en_i,
  input  coord_t              p_i,
  input  coord_t              lo_i,
  input  coord_t              hi_i,
  output logic [SQ_W-1:0]     sq_low_o,
  output logic [SQ_W-1:0]     sq_high_o,
  output clamp_e              clamp_o,
  output logic                inside_o
);

  logic signed [COORD_W:0] dl, dh, dl_neg, dh_neg;
  logic                    below, above;
  logic [COORD_W-1:0]      abs_lo_d, abs_hi_d;
  clamp_e                  clamp_d;

  logic [COORD_W-1:0]      abs_lo_q, abs_hi_q;
  clamp_e                  clamp2_q, clamp3_q;
  logic                    inside2_q, inside3_q;
  logic [SQ_W-1:0]         sq_lo_q, sq_hi_q;

  always_comb begin
    dl     = (COORD_W+1)'(p_i) - (COORD_W+1)'(lo_i);
    dh     = (COORD_W+1)'(p_i) - (COORD_W+1)'(hi_i);
    dl_neg = -dl;
    dh_neg = -dh;
    abs_lo_d = dl[COORD_W] ? dl_neg[COORD_W-1:0] : dl[COORD_W-1:0];
    abs_hi_d = dh[COORD_W] ? dh_neg[COORD_W-1:0] : dh[COORD_W-1:0];
    below  = dl[COORD_W];
    above  = !dh[COORD_W] && (dh != '0);
    // low bound is tested first, also for an inverted box
    if (below) begin
      clamp_d = CLAMP_LOW;
    end else if (above) begin
      clamp_d = CLAMP_HIGH;
    end else begin
      clamp_d = CLAMP_NONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      abs_lo_q  <= abs_lo_d;
      abs_hi_q  <= abs_hi_d;
      clamp2_q  <= clamp_d;
      inside2_q <= !below && !above;
    end
    if (en_i.s3) begin
      sq_lo_q   <= SQ_W'(abs_lo_q) * SQ_W'(abs_lo_q);
      sq_hi_q   <= SQ_W'(abs_hi_q) * SQ_W'(abs_hi_q);
      clamp3_q  <= clamp2_q;
      inside3_q <= inside2_q;
    end
  end

  assign sq_low_o  = sq_lo_q;
  assign sq_high_o = sq_hi_q;
  assign clamp_o   = clamp3_q;
  assign inside_o  = inside3_q;

endmodule

FILE: tb/sv/tb_point_box_squared_distance.sv
// self-checking testbench for the point to box squared distance block
// sends query points and box register writes, predicts every result word and compares it
// depends on pbsd_pkg and point_box_squared_distance

module tb_point_box_squared_distance;
  timeunit 1ns;
  timeprecision 1ps;

  import pbsd_pkg::*;

  // give the pipe a comfortable margin before touching the box
  localparam int unsigned DRAIN_CYCLES    = 12;
  // cycles with no word moving on any channel before the run is declared hung
  localparam int unsigned STALL_LIMIT     = 5000;
  localparam int unsigned ITEMS_PER_BOX   = 25;
  localparam int unsigned BOXES_PER_PHASE = 4;
  localparam int unsigned NUM_PHASES      = 4;
  localparam int unsigned MAX_REPORTS     = 50;
  localparam longint      DIST_CAP        = (longint'(1) << DIST_W) - 1;
  localparam int          COORD_MIN       = -(2 ** (COORD_W - 1));
  localparam int          COORD_MAX       = (2 ** (COORD_W - 1)) - 1;
  // indexes past the last box register, the block drops these writes
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(7);

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  point_in_t            in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  dist_out_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  coord_t               cfg_data  = '0;

  // shadow copy of the box registers, updated when a write is taken
  coord_t box_lo [NUM_AXES];
  coord_t box_hi [NUM_AXES];

  // expected result words, oldest first
  dist_out_t pending_dist [$];

  // percent of cycles the point sender idles and the result side stalls
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;

  int unsigned fail_count      = 0;
  int unsigned points_sent     = 0;
  int unsigned results_checked = 0;
  int unsigned boxes_loaded    = 0;
  int unsigned stuck_cycles    = 0;

  point_box_squared_distance dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // smallest squared distance over six clamped face points and eight corners,
  // plus the inclusive inside flag, all from the shadow box
  function automatic dist_out_t predict_distance(input point_in_t p);
    longint    pt [NUM_AXES];
    longint    q;
    longint    s;
    longint    best;
    dist_out_t r;
    pt[0] = longint'($signed(p.px));
    pt[1] = longint'($signed(p.py));
    pt[2] = longint'($signed(p.pz));
    best = DIST_CAP;
    r.inside_res = 1'b1;
    // candidates 0..5 are faces (axis c/2, high side when c is odd), 6..13 are corners
    for (int c = 0; c < 14; c++) begin
      s = 0;
      for (int k = 0; k < NUM_AXES; k++) begin
        if (c < 6 && k == c / 2) begin
          // fixed axis sits on the face plane
          q = (c % 2) ? box_hi[k] : box_lo[k];
        end else if (c < 6) begin
          // low bound tested first, which decides the pick on an inverted box
          if (pt[k] < box_lo[k]) begin
            q = box_lo[k];
          end else if (pt[k] > box_hi[k]) begin
            q = box_hi[k];
          end else begin
            q = pt[k];
          end
        end else begin
          q = (((c - 6) >> k) & 1) ? box_hi[k] : box_lo[k];
        end
        s += (pt[k] - q) * (pt[k] - q);
      end
      if (s > DIST_CAP) begin
        s = DIST_CAP;
      end
      if (s < best) begin
        best = s;
      end
    end
    for (int k = 0; k < NUM_AXES; k++) begin
      if (pt[k] < box_lo[k] || pt[k] > box_hi[k]) begin
        r.inside_res = 1'b0;
      end
    end
    r.min_sq_distance = best[DIST_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic int sat_coord(input longint v);
    if (v < COORD_MIN) begin
      return COORD_MIN;
    end
    if (v > COORD_MAX) begin
      return COORD_MAX;
    end
    return int'(v);
  endfunction

  function automatic int rand_coord();
    return COORD_MIN + int'($urandom_range(2 ** COORD_W - 1));
  endfunction

  function automatic point_in_t make_point(input int x, input int y, input int z);
    point_in_t p;
    p.px = coord_t'(x);
    p.py = coord_t'(y);
    p.pz = coord_t'(z);
    return p;
  endfunction

  // coordinate biased toward the current box: on a bound, between, just outside, or anywhere
  function automatic int pick_coord(input int k);
    int lo;
    int hi;
    int mn;
    int mx;
    lo = box_lo[k];
    hi = box_hi[k];
    mn = (lo < hi) ? lo : hi;
    mx = (lo < hi) ? hi : lo;
    case ($urandom_range(5))
      0:       return lo;
      1:       return hi;
      2:       return mn + int'($urandom_range(32'(mx - mn)));
      3:       return sat_coord(longint'(lo) - int'($urandom_range(300)));
      4:       return sat_coord(longint'(hi) + int'($urandom_range(300)));
      default: return rand_coord();
    endcase
  endfunction

  // one point in five is uniform over the whole coordinate range
  function automatic point_in_t random_point();
    if ($urandom_range(4) == 0) begin
      return make_point(rand_coord(), rand_coord(), rand_coord());
    end
    return make_point(pick_coord(0), pick_coord(1), pick_coord(2));
  endfunction

  // ---------------------------------------------------------------------------
  // channel drivers, all entered and left at a falling edge
  // ---------------------------------------------------------------------------

  // offer one point word, with random idle cycles ahead of it, and queue its prediction
  task automatic send_point(input point_in_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (in_stall);
    pending_dist.push_back(predict_distance(p));
    points_sent++;
    @(negedge clk);
  endtask

  // hold the sender off until every queued result has come back, then let the pipe settle
  task automatic settle_pipeline();
    in_valid <= 1'b0;
    while (pending_dist.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input coord_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_LOW_X:  box_lo[0] = value;
      REG_LOW_Y:  box_lo[1] = value;
      REG_LOW_Z:  box_lo[2] = value;
      REG_HIGH_X: box_hi[0] = value;
      REG_HIGH_Y: box_hi[1] = value;
      REG_HIGH_Z: box_hi[2] = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // reload the whole box, only once the block has nothing in flight
  task automatic set_box(input int lx, input int ly, input int lz,
                         input int hx, input int hy, input int hz);
    settle_pipeline();
    write_reg(REG_LOW_X, coord_t'(lx));
    write_reg(REG_LOW_Y, coord_t'(ly));
    write_reg(REG_LOW_Z, coord_t'(lz));
    write_reg(REG_HIGH_X, coord_t'(hx));
    write_reg(REG_HIGH_Y, coord_t'(hy));
    write_reg(REG_HIGH_Z, coord_t'(hz));
    boxes_loaded++;
  endtask

  // per axis: mostly a normal span up to 16.0, sometimes inverted, flat or full range
  task automatic load_random_box();
    int lo [NUM_AXES];
    int hi [NUM_AXES];
    for (int k = 0; k < NUM_AXES; k++) begin
      lo[k] = rand_coord();
      case ($urandom_range(9))
        0: hi[k] = rand_coord();
        1: hi[k] = lo[k];
        2: begin
          lo[k] = COORD_MIN;
          hi[k] = COORD_MAX;
        end
        default: hi[k] = sat_coord(longint'(lo[k]) + int'($urandom_range(4096)));
      endcase
    end
    set_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // box straight out of reset spans 0.0 .. 1.0
  task automatic test_reset_box();
    send_point(make_point(128, 128, 128));
    send_point(make_point(0, 0, 0));
    send_point(make_point(256, 256, 256));
    send_point(make_point(128, 128, -100));
    send_point(make_point(300, -5, 128));
    send_point(make_point(COORD_MIN, COORD_MIN, COORD_MIN));
    send_point(make_point(COORD_MAX, COORD_MAX, COORD_MAX));
    send_point(make_point(COORD_MIN, COORD_MAX, 0));
  endtask

  // full-range, flat and inverted boxes
  task automatic test_box_extremes();
    set_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
    send_point(make_point(0, 0, 0));
    send_point(make_point(COORD_MIN, COORD_MAX, -1));
    send_point(make_point(COORD_MAX, COORD_MIN, 100));

    // zero-size box, every candidate collapses to one point
    set_box(1000, -2000, 0, 1000, -2000, 0);
    send_point(make_point(1000, -2000, 0));
    send_point(make_point(1001, -1999, 5));

    // low above high on every axis, inside flag can never be set
    set_box(500, 500, 500, -500, -500, -500);
    send_point(make_point(0, 0, 0));
    send_point(make_point(600, -600, 0));
    send_point(make_point(COORD_MIN, COORD_MAX, 0));
  endtask

  // writes past the last register index must leave the box alone
  task automatic test_spare_indexes();
    set_box(-256, -256, -256, 256, 256, 256);
    write_reg(REG_SPARE_A, coord_t'(rand_coord()));
    write_reg(REG_SPARE_B, coord_t'(rand_coord()));
    write_reg(REG_SPARE_A, coord_t'(COORD_MIN));
    write_reg(REG_SPARE_B, coord_t'(COORD_MAX));
    send_point(make_point(0, 0, 0));
    send_point(make_point(300, -300, 1000));
  endtask

  // random boxes and points under four idle/stall mixes
  task automatic test_random_traffic();
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 62;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 62;
        end
        default: begin
          send_idle_pct = 11;
          stall_pct     = 11;
        end
      endcase
      for (int b = 0; b < BOXES_PER_PHASE; b++) begin
        load_random_box();
        for (int i = 0; i < ITEMS_PER_BOX; i++) begin
          // once per phase the sender waits for the pipe to run dry mid-stream
          if (b == 1 && i == ITEMS_PER_BOX / 2) begin
            settle_pipeline();
          end
          send_point(random_point());
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input longint want, input longint got);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("[%0t] mismatch, %s: expected %0d, got %0d", $realtime, what, want, got);
    end
  endtask

  // every taken result word is held against the oldest prediction
  always @(posedge clk) begin
    dist_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_dist.size() == 0) begin
        report_mismatch("result word with nothing pending", 0, out_data.min_sq_distance);
      end else begin
        want = pending_dist.pop_front();
        results_checked++;
        if (out_data.min_sq_distance !== want.min_sq_distance) begin
          report_mismatch("min_sq_distance", want.min_sq_distance, out_data.min_sq_distance);
        end
        if (out_data.inside_res !== want.inside_res) begin
          report_mismatch("inside_res", want.inside_res, out_data.inside_res);
        end
      end
    end
  end

  // result side back-pressure, redrawn every cycle
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  // hang detector: counts cycles in which no word moves on any channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        stuck_cycles <= 0;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= STALL_LIMIT) begin
        $display("timeout: no word moved for %0d cycles, %0d results outstanding",
                 stuck_cycles, pending_dist.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    for (int k = 0; k < NUM_AXES; k++) begin
      box_lo[k] = LOW_RESET;
      box_hi[k] = HIGH_RESET;
    end
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_box();
    test_box_extremes();
    test_spare_indexes();
    test_random_traffic();

    settle_pipeline();
    $display("sent %0d points over %0d box loads, checked %0d result words",
             points_sent, boxes_loaded, results_checked);
    $display("boxes: reset, full range, flat, inverted, random; spare indexes; idle and stall mixes");
    if (fail_count == 0 && pending_dist.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/pbsd_pkg.sv
sv/pbsd_axis.sv
sv/point_box_squared_distance.sv
tb/sv/tb_point_box_squared_distance.sv
